// ----- rtl/core/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Types and constants shared by the segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int unsigned CHUNK_BYTES_DEF  = 16;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned NUM_ORDERS_DEF   = 8;
  localparam int unsigned ARENA_BYTES_DEF  = 4096;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned ST_W   = 3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_LIST  = 3'd0,
    ST_TOP   = 3'd1,
    ST_FREED = 3'd2,
    ST_NULL  = 3'd3,
    ST_ORDER = 3'd4,
    ST_OOM   = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [ST_W-1:0]   status;
  } rsp_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic too_large;
    logic head_ok;
    logic top_fit;
    logic free_rej;
  } dec_flags_t;

endpackage

// ----- rtl/core/sfla_hdr_mem.sv -----
// ----------------------------------------------------------------------------
// sfla_hdr_mem
// Block header store: one word per chunk, one write and one registered read.
// ----------------------------------------------------------------------------
module sfla_hdr_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 15
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

endmodule

// ----- rtl/core/sfla_decode.sv -----
// ----------------------------------------------------------------------------
// sfla_decode
// Request decode: order search, list head lookup, header index and checks.
// ----------------------------------------------------------------------------
module sfla_decode #(
  parameter int unsigned CHUNK_BYTES  = sfla_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF,
  parameter int unsigned NUM_ORDERS   = sfla_pkg::NUM_ORDERS_DEF,
  parameter int unsigned ARENA_BYTES  = sfla_pkg::ARENA_BYTES_DEF,
  localparam int unsigned ORD_W       = $clog2(NUM_ORDERS),
  localparam int unsigned HDR_SLOTS   = ARENA_BYTES / CHUNK_BYTES,
  localparam int unsigned IDX_W       = $clog2(HDR_SLOTS),
  localparam int unsigned TOP_W       = $clog2(ARENA_BYTES) + 1
) (
  input  sfla_pkg::req_t                                 req_i,
  input  logic [NUM_ORDERS-1:0][sfla_pkg::ADDR_W-1:0]    heads_i,
  input  logic [TOP_W-1:0]                               top_i,
  output sfla_pkg::dec_flags_t                           flags_o,
  output logic [ORD_W-1:0]                               ord_o,
  output logic [IDX_W-1:0]                               idx_o,
  output logic [TOP_W-1:0]                               top_next_o
);

  localparam int unsigned AW     = sfla_pkg::ADDR_W;
  localparam int unsigned CSH    = $clog2(CHUNK_BYTES);
  localparam int unsigned NEED_W = sfla_pkg::SIZE_W + 1;
  localparam int unsigned IXW    = (IDX_W > AW) ? IDX_W : AW;
  localparam int unsigned BLK_W  = CSH + NUM_ORDERS;
  localparam int unsigned SUM_W  = ((BLK_W > TOP_W) ? BLK_W : TOP_W) + 1;
  localparam int unsigned CW     = (TOP_W > AW) ? TOP_W : AW;

  logic [NEED_W-1:0] need;
  logic              found;
  logic [ORD_W-1:0]  ord;
  logic [AW-1:0]     head;
  logic [AW-1:0]     head_hdr;
  logic [IXW-1:0]    head_ixf;
  logic [BLK_W-1:0]  blk;
  logic [SUM_W-1:0]  sum;
  logic [AW-1:0]     fhdr;
  logic [IXW-1:0]    fixf;

  always_comb begin
    need  = NEED_W'(req_i.size_bytes) + NEED_W'(HEADER_BYTES);
    found = 1'b0;
    ord   = '0;
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if (32'(need) <= (32'(CHUNK_BYTES) << k)) begin
        found = 1'b1;
        ord   = ORD_W'(k);
      end
    end
  end

  assign head     = heads_i[ord];
  assign head_hdr = head - AW'(HEADER_BYTES);
  assign head_ixf = IXW'(head_hdr >> CSH);
  assign blk      = BLK_W'(CHUNK_BYTES) << ord;
  assign sum      = SUM_W'(top_i) + SUM_W'(blk);
  assign fhdr     = req_i.block_address - AW'(HEADER_BYTES);
  assign fixf     = IXW'(fhdr >> CSH);

  always_comb begin
    flags_o.is_free   = (req_i.kind == sfla_pkg::KIND_FREE);
    flags_o.size_zero = (req_i.size_bytes == '0);
    flags_o.too_large = !found;
    flags_o.head_ok   = (32'(head) >= HEADER_BYTES) && (32'(head_ixf) < HDR_SLOTS);
    flags_o.top_fit   = (sum <= SUM_W'(ARENA_BYTES));
    flags_o.free_rej  = (req_i.block_address == '0)
                     || (32'(req_i.block_address) < HEADER_BYTES)
                     || (fhdr[CSH-1:0] != '0)
                     || (CW'(fhdr) >= CW'(top_i))
                     || (32'(fixf) >= HDR_SLOTS);
  end

  assign ord_o      = ord;
  assign idx_o      = (req_i.kind == sfla_pkg::KIND_FREE) ? fixf[IDX_W-1:0] : head_ixf[IDX_W-1:0];
  assign top_next_o = sum[TOP_W-1:0];

endmodule

// ----- rtl/core/segregated_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Power-of-two segregated free-list allocator over a fixed byte arena.
// ----------------------------------------------------------------------------
// A request is taken in S_IDLE, where the transfer cycle decodes the order and reads
// the block header from the header memory; S_EXEC then does the
// read-modify-write of that header, the list heads and the top pointer and
// loads the result register. S_EXEC is held while the result
// register still holds a result that has not been taken. Allocate pops the
// head of its order's LIFO list or bumps the top pointer; free pushes the
// block onto the list of the order stored in its header. The header memory
// needs no clearing after reset.
module segregated_free_list_allocator #(
  parameter int unsigned CHUNK_BYTES  = sfla_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = sfla_pkg::HEADER_BYTES_DEF,
  parameter int unsigned NUM_ORDERS   = sfla_pkg::NUM_ORDERS_DEF,
  parameter int unsigned ARENA_BYTES  = sfla_pkg::ARENA_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sfla_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sfla_pkg::rsp_t out_data_o
);

  localparam int unsigned AW        = sfla_pkg::ADDR_W;
  localparam int unsigned ORD_W     = $clog2(NUM_ORDERS);
  localparam int unsigned HDR_SLOTS = ARENA_BYTES / CHUNK_BYTES;
  localparam int unsigned IDX_W     = $clog2(HDR_SLOTS);
  localparam int unsigned TOP_W     = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned CSH       = $clog2(CHUNK_BYTES);
  localparam int unsigned MW        = ORD_W + AW;

  sfla_pkg::state_e                 state_q, state_d;
  logic [NUM_ORDERS-1:0][AW-1:0]    heads_q;
  logic [TOP_W-1:0]                 top_q;
  logic                             out_valid_q;
  sfla_pkg::rsp_t                   out_data_q;

  sfla_pkg::req_t                   req_q;
  sfla_pkg::dec_flags_t             flags_q, flags_d;
  logic [ORD_W-1:0]                 ord_q, ord_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [TOP_W-1:0]                 top_next_q, top_next_d;

  logic                             accept;
  logic                             commit;
  logic [MW-1:0]                    mem_rdata;
  logic [AW-1:0]                    rd_next;
  logic [ORD_W-1:0]                 rd_ord;

  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_idx;
  logic [MW-1:0]                    wr_data;
  logic                             heads_we;
  logic [ORD_W-1:0]                 heads_idx;
  logic [AW-1:0]                    heads_wdata;
  logic                             top_we;
  sfla_pkg::rsp_t                   rsp;

  sfla_decode #(
    .CHUNK_BYTES  (CHUNK_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .NUM_ORDERS   (NUM_ORDERS),
    .ARENA_BYTES  (ARENA_BYTES)
  ) u_decode (
    .req_i      (in_data_i),
    .heads_i    (heads_q),
    .top_i      (top_q),
    .flags_o    (flags_d),
    .ord_o      (ord_d),
    .idx_o      (idx_d),
    .top_next_o (top_next_d)
  );

  sfla_hdr_mem #(
    .DEPTH (HDR_SLOTS),
    .WIDTH (MW)
  ) u_hdr_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_idx_i  (idx_d),
    .rd_data_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfla_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sfla_pkg::S_EXEC;
        end
      end
      sfla_pkg::S_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = sfla_pkg::S_IDLE;
        end
      end
      default: state_d = sfla_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      sfla_pkg::S_IDLE: in_ready_o = 1'b1;
      sfla_pkg::S_EXEC: commit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept  = in_valid_i && in_ready_o;
  assign rd_next = mem_rdata[AW-1:0];
  assign rd_ord  = mem_rdata[MW-1:AW];

  // header read-modify-write and result
  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_data     = '0;
    heads_we    = 1'b0;
    heads_idx   = ord_q;
    heads_wdata = rd_next;
    top_we      = 1'b0;
    rsp.result_address = '0;
    rsp.status         = sfla_pkg::ST_NULL;
    if (!flags_q.is_free) begin
      if (flags_q.size_zero) begin
        rsp.status = sfla_pkg::ST_NULL;
      end else if (flags_q.too_large) begin
        rsp.status = sfla_pkg::ST_ORDER;
      end else if (flags_q.head_ok && (rd_ord == ord_q)) begin
        wr_en              = 1'b1;
        wr_data            = {rd_ord, AW'(0)};
        heads_we           = 1'b1;
        rsp.result_address = heads_q[ord_q];
        rsp.status         = sfla_pkg::ST_LIST;
      end else if (!flags_q.top_fit) begin
        rsp.status = sfla_pkg::ST_OOM;
      end else begin
        wr_en              = 1'b1;
        wr_idx             = top_q[CSH +: IDX_W];
        wr_data            = {ord_q, AW'(0)};
        top_we             = 1'b1;
        rsp.result_address = AW'(32'(top_q) + HEADER_BYTES);
        rsp.status         = sfla_pkg::ST_TOP;
      end
    end else begin
      if (flags_q.free_rej || (32'(rd_ord) >= NUM_ORDERS)) begin
        rsp.status = sfla_pkg::ST_NULL;
      end else if (heads_q[rd_ord] == req_q.block_address) begin
        rsp.status = sfla_pkg::ST_FREED;
      end else begin
        wr_en       = 1'b1;
        wr_data     = {rd_ord, heads_q[rd_ord]};
        heads_we    = 1'b1;
        heads_idx   = rd_ord;
        heads_wdata = req_q.block_address;
        rsp.status  = sfla_pkg::ST_FREED;
      end
    end
    wr_en    = wr_en && commit;
    heads_we = heads_we && commit;
    top_we   = top_we && commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfla_pkg::S_IDLE;
      heads_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (heads_we) begin
        heads_q[heads_idx] <= heads_wdata;
      end
      if (top_we) begin
        top_q <= top_next_q;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= in_data_i;
      flags_q    <= flags_d;
      ord_q      <= ord_d;
      idx_q      <= idx_d;
      top_next_q <= top_next_d;
    end
    if (commit) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
